/* rtl/tlbs_pkg.sv */
// Shared constants, codes and control types for the table search unit.
package tlbs_pkg;

    // Table geometry and field widths.
    localparam int TABLE_DEPTH = 64;
    localparam int ADDR_W      = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
    localparam int BND_W       = CNT_W + 1;
    localparam int DATA_W      = 32;
    localparam int IDX_W       = 6;
    localparam int LEN_W       = 7;
    localparam int POS_W       = 7;
    localparam int OP_W        = 2;

    // Operation codes carried by an input transaction.
    typedef enum logic [OP_W-1:0] {
        OP_WRITE  = 2'd0,
        OP_LINEAR = 2'd1,
        OP_BINARY = 2'd2
    } t_op;

    // Controller states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LIN,
        ST_BIN_PROBE,
        ST_BIN_CMP,
        ST_FIN
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic wr;
        logic lin_start;
        logic lin_issue;
        logic bin_start;
        logic bin_probe;
        logic bin_update;
        logic set_hit_lin;
        logic set_hit_bin;
        logic set_miss;
        logic out_load;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic lin_hit;
        logic lin_more;
        logic bin_empty;
        logic bin_eq;
        logic out_free;
    } t_stat;

endpackage

/* rtl/tlbs_ram.sv */
// Generic single-port RAM with registered read data.
module tlbs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // An optional write and a read per cycle at the shared address.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/tlbs_ctrl.sv */
// Controller state machine that sequences writes, linear and binary searches.
module tlbs_ctrl (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    output logic                     o_ready,
    input  logic [tlbs_pkg::OP_W-1:0] i_op,
    input  tlbs_pkg::t_stat          i_stat,
    output tlbs_pkg::t_cmd           o_cmd
);

    import tlbs_pkg::*;

    t_state r_state;
    t_state n_state;
    t_cmd   cmd;

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and commands.
    always_comb begin
        n_state = r_state;
        cmd     = '0;
        o_ready = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    unique case (t_op'(i_op))
                        OP_WRITE: begin
                            cmd.wr = 1'b1;
                        end
                        OP_LINEAR: begin
                            cmd.lin_start = 1'b1;
                            n_state       = ST_LIN;
                        end
                        OP_BINARY: begin
                            cmd.bin_start = 1'b1;
                            n_state       = ST_BIN_PROBE;
                        end
                        default: begin
                            n_state = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_LIN: begin
                // Check the entry read last cycle, then fetch the next one.
                if (i_stat.lin_hit) begin
                    cmd.set_hit_lin = 1'b1;
                    n_state         = ST_FIN;
                end else if (i_stat.lin_more) begin
                    cmd.lin_issue = 1'b1;
                end else begin
                    cmd.set_miss = 1'b1;
                    n_state      = ST_FIN;
                end
            end
            ST_BIN_PROBE: begin
                if (i_stat.bin_empty) begin
                    cmd.set_miss = 1'b1;
                    n_state      = ST_FIN;
                end else begin
                    cmd.bin_probe = 1'b1;
                    n_state       = ST_BIN_CMP;
                end
            end
            ST_BIN_CMP: begin
                if (i_stat.bin_eq) begin
                    cmd.set_hit_bin = 1'b1;
                    n_state         = ST_FIN;
                end else begin
                    cmd.bin_update = 1'b1;
                    n_state        = ST_BIN_PROBE;
                end
            end
            ST_FIN: begin
                // Hand the result to the output register once it has room.
                if (i_stat.out_free) begin
                    cmd.out_load = 1'b1;
                    n_state      = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_cmd = cmd;

    // A result is only loaded when the output register can take it.
    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.out_load |-> i_stat.out_free)
        else $error("result loaded into a full output register");

    // At most one result source is selected in a cycle.
    a_one_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({cmd.set_hit_lin, cmd.set_hit_bin, cmd.set_miss}))
        else $error("several result sources selected at once");

    // A binary compare always follows a probe that issued the read.
    a_cmp_after_probe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_BIN_CMP) |-> ($past(r_state) == ST_BIN_PROBE))
        else $error("binary compare without a preceding probe");

endmodule

/* rtl/tlbs_dp.sv */
// Datapath: table memory, search bounds, key compare and output register.
module tlbs_dp (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  tlbs_pkg::t_cmd               i_cmd,
    output tlbs_pkg::t_stat              o_stat,
    input  logic [tlbs_pkg::IDX_W-1:0]   i_entry_index,
    input  logic signed [tlbs_pkg::DATA_W-1:0] i_entry_value,
    input  logic signed [tlbs_pkg::DATA_W-1:0] i_search_key,
    input  logic                         i_cfg_valid,
    input  logic [tlbs_pkg::LEN_W-1:0]   i_cfg_data,
    input  logic                         i_out_ready,
    output logic                         o_out_valid,
    output logic                         o_found,
    output logic [tlbs_pkg::POS_W-1:0]   o_position
);

    import tlbs_pkg::*;

    logic [LEN_W-1:0]         r_list_length;
    logic signed [DATA_W-1:0] r_key;
    logic [CNT_W-1:0]         r_idx;
    logic [CNT_W-1:0]         n_idx;
    logic                     r_pend;
    logic [ADDR_W-1:0]        r_pend_addr;
    logic signed [BND_W-1:0]  r_lo;
    logic signed [BND_W-1:0]  n_lo;
    logic signed [BND_W-1:0]  r_hi;
    logic signed [BND_W-1:0]  n_hi;
    logic [ADDR_W-1:0]        r_mid;
    logic                     r_res_found;
    logic [POS_W-1:0]         r_res_pos;
    logic                     r_out_valid;
    logic                     r_out_found;
    logic [POS_W-1:0]         r_out_pos;

    logic [CNT_W-1:0]         used_len;
    logic [BND_W:0]           mid_sum;
    logic [ADDR_W-1:0]        mid;
    logic                     wr_ok;
    logic                     ram_we;
    logic [ADDR_W-1:0]        ram_addr;
    logic [DATA_W-1:0]        ram_rdata;
    logic signed [DATA_W-1:0] rd_value;
    t_stat                    stat;

    // Entries in use, capped at the table depth.
    assign used_len = (32'(r_list_length) > TABLE_DEPTH) ? CNT_W'(TABLE_DEPTH)
                                                          : CNT_W'(r_list_length);

    // Probe point of the binary search; both bounds are non-negative here.
    assign mid_sum = (BND_W + 1)'(r_lo) + (BND_W + 1)'(r_hi);
    assign mid     = ADDR_W'(mid_sum >> 1);

    // Memory port: writes from input transactions, reads for both searches.
    assign wr_ok  = 32'(i_entry_index) < TABLE_DEPTH;
    assign ram_we = i_cmd.wr && wr_ok;

    always_comb begin
        if (i_cmd.wr) begin
            ram_addr = ADDR_W'(i_entry_index);
        end else if (i_cmd.lin_issue) begin
            ram_addr = r_idx[ADDR_W-1:0];
        end else begin
            ram_addr = mid;
        end
    end

    tlbs_ram #(
        .WIDTH (DATA_W),
        .DEPTH (TABLE_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_addr  (ram_addr),
        .i_wdata (i_entry_value),
        .o_rdata (ram_rdata)
    );

    assign rd_value = $signed(ram_rdata);

    // Status back to the controller.
    always_comb begin
        stat           = '0;
        stat.lin_hit   = r_pend && (rd_value == r_key);
        stat.lin_more  = r_idx < used_len;
        stat.bin_empty = r_lo > r_hi;
        stat.bin_eq    = rd_value == r_key;
        stat.out_free  = !r_out_valid || i_out_ready;
    end
    assign o_stat = stat;

    // Next search bounds and scan index.
    always_comb begin
        n_idx = r_idx;
        n_lo  = r_lo;
        n_hi  = r_hi;
        if (i_cmd.lin_start) begin
            n_idx = '0;
        end else if (i_cmd.lin_issue) begin
            n_idx = r_idx + 1'b1;
        end
        if (i_cmd.bin_start) begin
            n_lo = '0;
            n_hi = $signed(BND_W'(used_len)) - BND_W'(1);
        end else if (i_cmd.bin_update) begin
            if (rd_value < r_key) begin
                n_lo = $signed(BND_W'(r_mid)) + BND_W'(1);
            end else begin
                n_hi = $signed(BND_W'(r_mid)) - BND_W'(1);
            end
        end
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_list_length <= '0;
            r_pend        <= 1'b0;
            r_out_valid   <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_list_length <= i_cfg_data;
            end
            r_pend <= i_cmd.lin_issue;
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_idx <= n_idx;
        r_lo  <= n_lo;
        r_hi  <= n_hi;
        if (i_cmd.lin_start || i_cmd.bin_start) begin
            r_key <= i_search_key;
        end
        if (i_cmd.lin_issue) begin
            r_pend_addr <= r_idx[ADDR_W-1:0];
        end
        if (i_cmd.bin_probe) begin
            r_mid <= mid;
        end
        if (i_cmd.set_hit_lin) begin
            r_res_found <= 1'b1;
            r_res_pos   <= POS_W'(32'(r_pend_addr) + 1);
        end else if (i_cmd.set_hit_bin) begin
            r_res_found <= 1'b1;
            r_res_pos   <= POS_W'(32'(r_mid) + 1);
        end else if (i_cmd.set_miss) begin
            r_res_found <= 1'b0;
            r_res_pos   <= '0;
        end
        if (i_cmd.out_load) begin
            r_out_found <= r_res_found;
            r_out_pos   <= r_res_pos;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_found     = r_out_found;
    assign o_position  = r_out_pos;

    // A miss never reports a position.
    a_miss_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_cmd.set_miss) |-> (!r_res_found && (r_res_pos == '0)))
        else $error("missed search carries a nonzero position");

    // A linear hit only comes from a read issued the cycle before.
    a_hit_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.set_hit_lin |-> $past(i_cmd.lin_issue))
        else $error("linear hit without a pending table read");

    // The binary probe point stays within the used part of the table.
    a_probe_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.bin_probe |-> (CNT_W'(mid) < used_len))
        else $error("binary probe outside the used entries");

endmodule

/* rtl/table_linear_binary_search_unit.sv */
// Top level of the searchable table: controller, datapath and port wiring.
//
//  Channel   Direction  Handshake                 Payload
//  input     in         i_valid / o_ready         i_op, i_entry_index, i_entry_value,
//                                                 i_search_key
//  result    out        o_valid / i_ready         o_found, o_position
//  config    in         i_cfg_valid / o_cfg_ready i_cfg_data (list length)
//
// A linear search makes one table read per cycle through the single RAM port; a binary
// search makes a read, then a compare, for each probe.
// Reset is synchronous and active low; it clears the list length and control state,
// while table entries stay undefined until written.
// The output register holds a finished result, so a new transaction is accepted while
// it waits; a further result then stalls in the controller until the slot frees up.
module table_linear_binary_search_unit (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_ready,
    input  logic [tlbs_pkg::OP_W-1:0]           i_op,
    input  logic [tlbs_pkg::IDX_W-1:0]          i_entry_index,
    input  logic signed [tlbs_pkg::DATA_W-1:0]  i_entry_value,
    input  logic signed [tlbs_pkg::DATA_W-1:0]  i_search_key,
    output logic                                o_valid,
    input  logic                                i_ready,
    output logic                                o_found,
    output logic [tlbs_pkg::POS_W-1:0]          o_position,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [tlbs_pkg::LEN_W-1:0]          i_cfg_data
);

    import tlbs_pkg::*;

    t_cmd  cmd;
    t_stat stat;

    // The list length register takes a write in any cycle.
    assign o_cfg_ready = 1'b1;

    tlbs_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_op    (i_op),
        .i_stat  (stat),
        .o_cmd   (cmd)
    );

    tlbs_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_stat        (stat),
        .i_entry_index (i_entry_index),
        .i_entry_value (i_entry_value),
        .i_search_key  (i_search_key),
        .i_cfg_valid   (i_cfg_valid),
        .i_cfg_data    (i_cfg_data),
        .i_out_ready   (i_ready),
        .o_out_valid   (o_valid),
        .o_found       (o_found),
        .o_position    (o_position)
    );

endmodule

/* verif/table_linear_binary_search_unit_tb.sv */
// Self-checking testbench for the table search unit with a built-in table and search predictor.
module table_linear_binary_search_unit_tb;
    import tlbs_pkg::*;

    localparam logic [OP_W-1:0]          OP_UNUSED     = 2'd3;
    localparam logic signed [DATA_W-1:0] DATA_MIN      = 32'sh8000_0000;
    localparam logic signed [DATA_W-1:0] DATA_MAX      = 32'sh7FFF_FFFF;
    localparam int                       MAX_GAP       = 18;
    localparam int                       SETTLE_CYCLES = 80;
    localparam int                       STALL_LIMIT   = 3000;
    localparam int                       ITEM_TARGET   = 1350;

    typedef struct {
        logic             found;
        logic [POS_W-1:0] position;
    } t_lookup_result;

    logic                      i_clk         = 1'b0;
    logic                      i_rst_n       = 1'b0;
    logic                      i_valid       = 1'b0;
    logic                      o_ready;
    logic [OP_W-1:0]           i_op          = '0;
    logic [IDX_W-1:0]          i_entry_index = '0;
    logic signed [DATA_W-1:0]  i_entry_value = '0;
    logic signed [DATA_W-1:0]  i_search_key  = '0;
    logic                      o_valid;
    logic                      i_ready       = 1'b0;
    logic                      o_found;
    logic [POS_W-1:0]          o_position;
    logic                      i_cfg_valid   = 1'b0;
    logic                      o_cfg_ready;
    logic [LEN_W-1:0]          i_cfg_data    = '0;

    // Mirror of the table and the list length, updated as transactions are accepted.
    logic signed [DATA_W-1:0]  table_mirror [TABLE_DEPTH];
    logic [LEN_W-1:0]          table_len = '0;
    t_lookup_result            pending_lookups [$];

    logic no_gaps = 1'b0;
    int   error_count     = 0;
    int   results_checked = 0;
    int   items_sent      = 0;
    int   n_writes        = 0;
    int   n_linear        = 0;
    int   n_binary        = 0;
    int   n_ignored       = 0;
    int   lengths_set     = 0;
    int   sink_hold       = 0;
    int   stall_cycles    = 0;

    table_linear_binary_search_unit dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_op          (i_op),
        .i_entry_index (i_entry_index),
        .i_entry_value (i_entry_value),
        .i_search_key  (i_search_key),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_found       (o_found),
        .o_position    (o_position),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data)
    );

    always #1 i_clk = ~i_clk;

    // Number of entries a search looks at; lengths beyond the depth saturate.
    function automatic int used_entries();
        return (int'(table_len) > TABLE_DEPTH) ? TABLE_DEPTH : int'(table_len);
    endfunction

    // Lowest 1-based position holding the key, or 0.
    function automatic logic [POS_W-1:0] lookup_linear(input logic signed [DATA_W-1:0] key);
        int n;
        n = used_entries();
        for (int i = 0; i < n; i++) begin
            if (table_mirror[i] == key) return POS_W'(i + 1);
        end
        return '0;
    endfunction

    // Midpoint probing over the used entries, whatever their order.
    function automatic logic [POS_W-1:0] lookup_binary(input logic signed [DATA_W-1:0] key);
        int lo;
        int hi;
        int mid;
        lo = 0;
        hi = used_entries() - 1;
        while (lo <= hi) begin
            mid = (lo + hi) / 2;
            if (table_mirror[mid] < key) lo = mid + 1;
            else if (table_mirror[mid] == key) return POS_W'(mid + 1);
            else hi = mid - 1;
        end
        return '0;
    endfunction

    // Present one input transaction after a random gap and record its effect once accepted.
    task automatic send_item(input logic [OP_W-1:0] op, input logic [IDX_W-1:0] idx,
                             input logic signed [DATA_W-1:0] value,
                             input logic signed [DATA_W-1:0] key);
        int               gap;
        logic [POS_W-1:0] pos;
        t_lookup_result   lookup;
        gap = no_gaps ? 0 : $urandom_range(0, MAX_GAP);
        if (gap != 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid       <= 1'b1;
        i_op          <= op;
        i_entry_index <= idx;
        i_entry_value <= value;
        i_search_key  <= key;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        if (op == OP_WRITE) begin
            table_mirror[idx] = value;
            n_writes++;
            items_sent++;
        end else if (op == OP_LINEAR || op == OP_BINARY) begin
            pos = (op == OP_LINEAR) ? lookup_linear(key) : lookup_binary(key);
            lookup.found    = (pos != '0);
            lookup.position = pos;
            pending_lookups.push_back(lookup);
            if (op == OP_LINEAR) n_linear++;
            else n_binary++;
            items_sent++;
        end else begin
            n_ignored++;
        end
    endtask

    // Search with don't-care write fields randomized.
    task automatic send_search(input logic [OP_W-1:0] op, input logic signed [DATA_W-1:0] key);
        send_item(op, IDX_W'($urandom), DATA_W'($urandom), key);
    endtask

    // Let all results drain, then give a write or a search in flight time to finish.
    task automatic wait_idle();
        i_valid <= 1'b0;
        while (pending_lookups.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Write the list length register while the block is idle.
    task automatic write_list_length(input logic [LEN_W-1:0] len);
        wait_idle();
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= len;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        table_len = len;
        lengths_set++;
        i_cfg_valid <= 1'b0;
    endtask

    // One phase: set a length, fill the used entries, then search with some noise mixed in.
    task automatic run_phase(input logic [LEN_W-1:0] len);
        int          used;
        int          shape;
        int          searches;
        int          pick;
        int          k;
        int unsigned span;
        int unsigned offset;
        longint      room;
        longint      acc;
        logic signed [DATA_W-1:0] key;
        no_gaps = ($urandom_range(0, 4) == 0);
        write_list_length(len);
        used  = used_entries();
        shape = $urandom_range(0, 4);
        case (shape)
            1:       span = 3;
            2:       span = 1000;
            default: span = 32'hFFFF_FFFF / 32'(used + 1);
        endcase
        room   = longint'(32'hFFFF_FFFF) - longint'(used) * longint'(span);
        offset = $urandom_range(0, 32'(room));
        acc    = -64'sd2147483648 + longint'(offset);
        // Fill entries in ascending order, except for the unsorted shape.
        for (int i = 0; i < used; i++) begin
            if (i != 0) acc = acc + longint'($urandom_range(0, span));
            if (shape == 0) send_item(OP_WRITE, IDX_W'(i), DATA_W'($urandom), DATA_W'($urandom));
            else send_item(OP_WRITE, IDX_W'(i), acc[31:0], DATA_W'($urandom));
        end
        searches = $urandom_range(4, 20);
        for (int s = 0; s < searches; s++) begin
            pick = $urandom_range(0, 11);
            if (pick == 11) begin
                send_item(OP_UNUSED, IDX_W'($urandom), DATA_W'($urandom), DATA_W'($urandom));
            end else if (pick == 10) begin
                send_item(OP_WRITE, IDX_W'($urandom), DATA_W'($urandom), DATA_W'($urandom));
            end else begin
                if (used > 0 && pick < 6) begin
                    k   = $urandom_range(0, used - 1);
                    key = table_mirror[k];
                end else if (pick == 6) begin
                    k   = $urandom_range(0, TABLE_DEPTH - 1);
                    key = table_mirror[k];
                end else if (used > 0 && pick == 7) begin
                    k   = $urandom_range(0, used - 1);
                    key = $urandom_range(0, 1) ? table_mirror[k] + 32'sd1
                                               : table_mirror[k] - 32'sd1;
                end else begin
                    key = DATA_W'($urandom);
                end
                send_search($urandom_range(0, 1) ? OP_LINEAR : OP_BINARY, key);
            end
        end
    endtask

    // Empty list: every search misses, and the unused op gives nothing.
    task automatic test_empty_list();
        write_list_length(7'd0);
        send_search(OP_LINEAR, 32'sd0);
        send_search(OP_BINARY, DATA_MIN);
        send_item(OP_UNUSED, '1, '1, '1);
    endtask

    // Small ascending table with both value extremes and a write beyond the used length.
    task automatic test_small_sorted();
        write_list_length(7'd5);
        send_item(OP_WRITE, 6'd0, DATA_MIN, DATA_W'($urandom));
        send_item(OP_WRITE, 6'd1, -32'sd7, DATA_W'($urandom));
        send_item(OP_WRITE, 6'd2, 32'sd0, DATA_W'($urandom));
        send_item(OP_WRITE, 6'd3, 32'sd9, DATA_W'($urandom));
        send_item(OP_WRITE, 6'd4, DATA_MAX, DATA_W'($urandom));
        send_search(OP_LINEAR, DATA_MIN);
        send_search(OP_LINEAR, DATA_MAX);
        send_search(OP_LINEAR, 32'sd8);
        send_search(OP_BINARY, 32'sd0);
        send_search(OP_BINARY, DATA_MIN);
        send_search(OP_BINARY, DATA_MAX);
        send_search(OP_BINARY, 32'sd10);
        send_item(OP_WRITE, 6'd63, 32'sh5A5A_A5A5, DATA_W'($urandom));
        send_search(OP_LINEAR, 32'sh5A5A_A5A5);
    endtask

    // Break the ordering so binary search follows its probes over an unsorted table.
    task automatic test_unsorted_table();
        send_item(OP_WRITE, 6'd1, DATA_MAX, DATA_W'($urandom));
        send_search(OP_BINARY, 32'sd9);
        send_search(OP_LINEAR, DATA_MAX);
        send_search(OP_BINARY, DATA_MAX);
    endtask

    // Full table, lengths beyond the depth, and the shortest lists.
    task automatic test_length_extremes();
        run_phase(7'd64);
        run_phase(7'd127);
        run_phase(7'd65);
        run_phase(7'd1);
        run_phase(7'd2);
    endtask

    // Random phases, mostly short lists and now and then a long one.
    task automatic test_random_phases();
        while (items_sent < ITEM_TARGET) begin
            if ($urandom_range(0, 9) == 0) run_phase(LEN_W'($urandom_range(33, 127)));
            else run_phase(LEN_W'($urandom_range(0, 16)));
        end
    endtask

    // Result side: random ready stalls and comparison against the oldest expected lookup.
    always @(posedge i_clk) begin : result_check
        t_lookup_result exp_r;
        int             wait_draw;
        if (!i_rst_n) begin
            i_ready   <= 1'b0;
            sink_hold <= 0;
        end else if (o_valid && i_ready) begin
            if (pending_lookups.size() == 0) begin
                $display("%0t: result with no lookup pending: found=%0b position=%0d",
                         $time, o_found, o_position);
                error_count++;
            end else begin
                exp_r = pending_lookups.pop_front();
                if (o_found !== exp_r.found) begin
                    $display("%0t: found mismatch: expected %0b, actual %0b",
                             $time, exp_r.found, o_found);
                    error_count++;
                end
                if (o_position !== exp_r.position) begin
                    $display("%0t: position mismatch: expected %0d, actual %0d",
                             $time, exp_r.position, o_position);
                    error_count++;
                end
                results_checked++;
            end
            wait_draw = no_gaps ? 0 : $urandom_range(0, MAX_GAP);
            i_ready   <= (wait_draw == 0);
            sink_hold <= wait_draw;
        end else if (sink_hold > 1) begin
            sink_hold <= sink_hold - 1;
        end else begin
            sink_hold <= 0;
            i_ready   <= 1'b1;
        end
    end

    // Watchdog: ends the run when no transaction of any channel completes for too long.
    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready) || (i_cfg_valid && o_cfg_ready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("%0t: no transaction for %0d cycles", $time, STALL_LIMIT);
            $display("DONE: errors detected");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial begin
        for (int i = 0; i < TABLE_DEPTH; i++) table_mirror[i] = '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_empty_list();
        test_small_sorted();
        test_unsorted_table();
        test_length_extremes();
        test_random_phases();
        wait_idle();
        $display("Sent %0d transactions: %0d writes, %0d linear and %0d binary searches, %0d unused ops.",
                 items_sent + n_ignored, n_writes, n_linear, n_binary, n_ignored);
        $display("Checked %0d search results across %0d list length settings.",
                 results_checked, lengths_set);
        if (pending_lookups.size() != 0) begin
            $display("%0t: %0d expected results never arrived", $time, pending_lookups.size());
        end
        if (error_count == 0 && pending_lookups.size() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
